// ===== rtl/sacc_pkg.sv =====
// Shared types and constants for the set-associative cache tag controller.
package sacc_pkg;

  localparam int DEF_SETS        = 256;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_BLOCK_BYTES = 16;

  localparam int ADDR_W  = 32;
  localparam int COST_W  = 17;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 48;
  localparam int CFG_IDX_W = 2;

  // Modelled cost of a memory write, per word.
  localparam int MEM_COST = 100;
  localparam int WORD_BYTES = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_ALLOCATE = 2'd0,
    CFG_WRITE_BACK     = 2'd1,
    CFG_REPLACE_LRU    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ===== rtl/set_assoc_cache_tag_controller.sv =====
// Top level of the set-associative cache tag controller.
//
//   channel   handshake               payload
//   access    start / busy            command, address
//   result    done (one cycle)        hit, cycles_added, counts, cycle_total
//   config    write_enable            write_index, write_data
//
// For an access, the set row is read from the set memory at the accept edge,
// and the next cycle updates it and the counters.
// A new access may be accepted in the cycle its predecessor's result is shown.
// After reset a clearing pass writes each of the 2^floor(log2 SETS) set rows
// (256 by default), one per cycle; busy stays high meanwhile.
// The result receiver cannot stall.
module set_assoc_cache_tag_controller #(
  parameter int SETS        = sacc_pkg::DEF_SETS,
  parameter int WAYS        = sacc_pkg::DEF_WAYS,
  parameter int BLOCK_BYTES = sacc_pkg::DEF_BLOCK_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [sacc_pkg::ADDR_W-1:0]       address,
  input  logic                              write_enable,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]    write_index,
  input  logic                              write_data,
  output logic                              done,
  output logic                              hit,
  output logic [sacc_pkg::COST_W-1:0]       cycles_added,
  output logic [sacc_pkg::COUNT_W-1:0]      load_hit_count,
  output logic [sacc_pkg::COUNT_W-1:0]      load_miss_count,
  output logic [sacc_pkg::COUNT_W-1:0]      store_hit_count,
  output logic [sacc_pkg::COUNT_W-1:0]      store_miss_count,
  output logic [sacc_pkg::TOTAL_W-1:0]      cycle_total
);
  import sacc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sacc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sacc_datapath #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .write_enable     (write_enable),
    .write_index      (write_index),
    .write_data       (write_data),
    .command          (command),
    .address          (address),
    .done             (done),
    .hit              (hit),
    .cycles_added     (cycles_added),
    .load_hit_count   (load_hit_count),
    .load_miss_count  (load_miss_count),
    .store_hit_count  (store_hit_count),
    .store_miss_count (store_miss_count),
    .cycle_total      (cycle_total)
  );

endmodule

// ===== rtl/sacc_ctrl.sv =====
// Controller state machine: tag store clearing pass, accept and commit sequencing.
module sacc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sacc_pkg::dp_status_t status,
  output sacc_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import sacc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    cmd.clear   = (state == ST_CLEAR);
    cmd.capture = (state == ST_IDLE) && start;
    cmd.commit  = (state == ST_LOOKUP);
  end

endmodule

// ===== rtl/sacc_datapath.sv =====
// Datapath: set memory, hit search, replacement ranks, cost and running counters.
module sacc_datapath #(
  parameter int SETS        = sacc_pkg::DEF_SETS,
  parameter int WAYS        = sacc_pkg::DEF_WAYS,
  parameter int BLOCK_BYTES = sacc_pkg::DEF_BLOCK_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sacc_pkg::ctrl_cmd_t               cmd,
  output sacc_pkg::dp_status_t              status,
  input  logic                              write_enable,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]    write_index,
  input  logic                              write_data,
  input  logic                              command,
  input  logic [sacc_pkg::ADDR_W-1:0]       address,
  output logic                              done,
  output logic                              hit,
  output logic [sacc_pkg::COST_W-1:0]       cycles_added,
  output logic [sacc_pkg::COUNT_W-1:0]      load_hit_count,
  output logic [sacc_pkg::COUNT_W-1:0]      load_miss_count,
  output logic [sacc_pkg::COUNT_W-1:0]      store_hit_count,
  output logic [sacc_pkg::COUNT_W-1:0]      store_miss_count,
  output logic [sacc_pkg::TOTAL_W-1:0]      cycle_total
);
  import sacc_pkg::*;

  localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IDX_BITS = $clog2(SETS + 1) - 1;
  localparam int SET_W    = (IDX_BITS == 0) ? 1 : IDX_BITS;
  localparam int ROWS     = 1 << IDX_BITS;
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int RANK_W   = (WAYS == 1) ? 1 : $clog2(WAYS);
  localparam int FILL     = MEM_COST * (BLOCK_BYTES / WORD_BYTES);
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rrank;
    logic [RANK_W-1:0] arank;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  row_t mem [ROWS];
  row_t row_q;
  row_t row_next;
  row_t reset_row;

  logic [SET_W-1:0] clr_ptr;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             store_q;

  logic [ADDR_W-1:0] set_full;
  logic [ADDR_W-1:0] tag_full;

  logic write_allocate;
  logic wback_mode;
  logic replace_lru;

  logic              hit_w;
  logic [RANK_W-1:0] hw;
  logic [RANK_W-1:0] victim;
  logic [RANK_W-1:0] victim_lru;
  logic [RANK_W-1:0] victim_fifo;
  logic [RANK_W-1:0] hit_rank;
  logic              wb;
  logic [COST_W-1:0] cost;
  logic [TOTAL_W:0]  total_sum;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_allocate <= 1'b1;
      wback_mode     <= 1'b1;
      replace_lru    <= 1'b1;
    end else if (write_enable) begin
      unique case (write_index)
        CFG_WRITE_ALLOCATE: write_allocate <= write_data;
        CFG_WRITE_BACK:     wback_mode     <= write_data;
        CFG_REPLACE_LRU:    replace_lru    <= write_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      reset_row[w].valid = 1'b0;
      reset_row[w].dirty = 1'b0;
      reset_row[w].tag   = '0;
      reset_row[w].rrank = RANK_W'(w);
      reset_row[w].arank = RANK_W'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  assign status.clear_last = (clr_ptr == SET_W'(ROWS - 1));

  assign set_full = (address >> OFF_BITS) & SET_MASK;
  assign tag_full = address >> (OFF_BITS + IDX_BITS);

  // Set memory: one row holds every way of a set.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_ptr] <= reset_row;
    end else if (cmd.commit) begin
      mem[set_q] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q   <= mem[set_full[SET_W-1:0]];
      set_q   <= set_full[SET_W-1:0];
      tag_q   <= tag_full[TAG_W-1:0];
      store_q <= command;
    end
  end

  // Hit search and victim selection.
  always_comb begin
    hit_w       = 1'b0;
    hw          = '0;
    victim_lru  = '0;
    victim_fifo = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_w && row_q[w].valid && row_q[w].tag == tag_q) begin
        hit_w = 1'b1;
        hw    = RANK_W'(w);
      end
      if (row_q[w].rrank == RANK_W'(WAYS - 1)) victim_lru = RANK_W'(w);
      if (row_q[w].arank == '0) victim_fifo = RANK_W'(w);
    end
    victim   = replace_lru ? victim_lru : victim_fifo;
    hit_rank = row_q[hw].rrank;
    wb       = wback_mode && write_allocate;
  end

  // Row update and access cost.
  always_comb begin
    row_next = row_q;
    cost     = COST_W'(1);
    if (hit_w) begin
      if (replace_lru) begin
        for (int w = 0; w < WAYS; w++) begin
          if (RANK_W'(w) != hw && row_q[w].rrank < hit_rank) begin
            row_next[w].rrank = row_q[w].rrank + 1'b1;
          end
        end
        row_next[hw].rrank = '0;
      end
      if (store_q) begin
        if (wb) row_next[hw].dirty = 1'b1;
        else cost = cost + COST_W'(MEM_COST);
      end
    end else if (store_q && !write_allocate) begin
      cost = cost + COST_W'(MEM_COST);
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (replace_lru) begin
          if (RANK_W'(w) == victim) row_next[w].rrank = '0;
          else if (row_q[w].rrank < RANK_W'(WAYS - 1))
            row_next[w].rrank = row_q[w].rrank + 1'b1;
        end else begin
          if (RANK_W'(w) == victim) row_next[w].arank = RANK_W'(WAYS - 1);
          else if (row_q[w].arank > '0) row_next[w].arank = row_q[w].arank - 1'b1;
        end
      end
      cost = cost + COST_W'(FILL);
      // A dirty victim is written back before the fill.
      if (row_q[victim].dirty) cost = cost + COST_W'(FILL);
      row_next[victim].tag   = tag_q;
      row_next[victim].valid = 1'b1;
      row_next[victim].dirty = store_q && wb;
      if (store_q && !wb) cost = cost + COST_W'(MEM_COST);
    end
  end

  assign total_sum = {1'b0, cycle_total} + (TOTAL_W + 1)'(cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      load_hit_count   <= '0;
      load_miss_count  <= '0;
      store_hit_count  <= '0;
      store_miss_count <= '0;
      cycle_total      <= '0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        if (!store_q && hit_w && load_hit_count != '1)
          load_hit_count <= load_hit_count + 1'b1;
        if (!store_q && !hit_w && load_miss_count != '1)
          load_miss_count <= load_miss_count + 1'b1;
        if (store_q && hit_w && store_hit_count != '1)
          store_hit_count <= store_hit_count + 1'b1;
        if (store_q && !hit_w && store_miss_count != '1)
          store_miss_count <= store_miss_count + 1'b1;
        cycle_total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= hit_w;
      cycles_added <= cost;
    end
  end

endmodule

// ===== rtl/sacc_checker.sv =====
// Port-level checks for the cache tag controller, bound to the top level.
module sacc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              hit,
  input logic [sacc_pkg::COST_W-1:0]       cycles_added,
  input logic [sacc_pkg::TOTAL_W-1:0]      cycle_total
);
  import sacc_pkg::*;

  // Every result follows an accepted transaction, through its lookup state and the registered done.
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, 2) && !$past(rst) |-> $past(start && !busy, 2))
    else $error("result without a matching transaction");

  // An accepted transaction raises busy in the next cycle, blocking the next accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // A hit never fills a line.
  a_hit_cost: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> cycles_added == COST_W'(1) || cycles_added == COST_W'(1 + MEM_COST))
    else $error("hit with fill cost");

  // The running total moves only with a result.
  a_total_stable: assert property (@(posedge clk) disable iff (rst)
    !done && !$past(rst) |-> $stable(cycle_total))
    else $error("cycle total changed without a result");

endmodule

bind set_assoc_cache_tag_controller sacc_checker u_sacc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .hit          (hit),
  .cycles_added (cycles_added),
  .cycle_total  (cycle_total)
);
